[rtl/core/glq_pkg.sv]
// ----------------------------------------------------------------------------
// glq_pkg: shared types and constants for the glyph quad layout block
// Command format between front and back, status codes, register indexes,
// queue and divider sizing, and the 16-bit saturation helper.
// ----------------------------------------------------------------------------
package glq_pkg;

    localparam int GLYPH_COUNT = 256;
    localparam int GLYPH_AW    = $clog2(GLYPH_COUNT);

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [16:0] Q16_ONE = 17'h10000;

    // quotient bits retired per divider cycle, after the leading bit
    localparam int DIV_RADIX_BITS = 4;
    localparam int DIV_STEPS      = 16 / DIV_RADIX_BITS;
    localparam int DIV_CNT_W      = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [1:0] CFG_LINE_HEIGHT  = 2'd0;
    localparam logic [1:0] CFG_ATLAS_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_ATLAS_HEIGHT = 2'd2;

    typedef enum logic [1:0] {
        ACT_STORE  = 2'd0,
        ACT_LAYOUT = 2'd1,
        ACT_START  = 2'd2,
        ACT_UNUSED = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_STORED       = 3'd0,
        ST_QUAD         = 3'd1,
        ST_LINE_BREAK   = 3'd2,
        ST_NOTHING      = 3'd3,
        ST_CURSOR_RESET = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        K_STORED  = 3'd0,
        K_START   = 3'd1,
        K_NEWLINE = 3'd2,
        K_GLYPH   = 3'd3,
        K_NONE    = 3'd4
    } t_kind;

    typedef struct packed {
        logic [11:0] atlas_x;
        logic [11:0] atlas_y;
        logic [7:0]  width;
        logic [7:0]  height;
        logic [7:0]  off_x;
        logic [7:0]  off_y;
        logic [7:0]  advance;
    } t_glyph;

    typedef struct packed {
        t_kind  kind;
        t_glyph glyph;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  line_height;
        logic [12:0] atlas_width;
        logic [12:0] atlas_height;
    } t_cfg;

    function automatic logic [15:0] sat16(input logic signed [17:0] v);
        logic [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'h7fff;
        end else if (v < -18'sd32768) begin
            r = 16'h8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

[rtl/core/glq_front.sv]
// ----------------------------------------------------------------------------
// glq_front: input side of the glyph quad layout block
// Owns the glyph table, applies store items, looks up layout items with
// fallback to entry 0, and hands classified commands to the queue.
// ----------------------------------------------------------------------------
module glq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [1:0]     i_action,
    input  logic [7:0]     i_char_code,
    input  logic           i_glyph_present,
    input  glq_pkg::t_glyph i_glyph,
    output logic           o_push,
    output glq_pkg::t_cmd  o_cmd,
    input  logic           i_full
);
    import glq_pkg::*;

    logic [GLYPH_COUNT-1:0] r_valid;
    t_glyph                 r_mem [GLYPH_COUNT];

    logic   r_fv;
    t_kind  r_kind;
    logic   r_present;
    t_glyph r_rd;

    logic                w_accept;
    logic                w_in_range;
    logic [GLYPH_AW-1:0] w_code_idx;
    logic [GLYPH_AW-1:0] w_idx;
    logic                w_store;
    t_kind               w_kind;

    assign w_accept   = i_valid && !o_stall;
    assign w_in_range = (int'(i_char_code) < GLYPH_COUNT);
    assign w_code_idx = i_char_code[GLYPH_AW-1:0];
    // fall back to entry 0 when the requested entry is absent
    assign w_idx      = (w_in_range && r_valid[w_code_idx]) ? w_code_idx : '0;
    assign w_store    = w_accept && (t_action'(i_action) == ACT_STORE) && w_in_range;

    always_comb begin
        case (t_action'(i_action))
            ACT_STORE:  w_kind = K_STORED;
            ACT_START:  w_kind = K_START;
            ACT_LAYOUT: w_kind = (i_char_code == NEWLINE_CODE) ? K_NEWLINE : K_GLYPH;
            default:    w_kind = K_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv    <= 1'b0;
            r_valid <= '0;
        end else begin
            if (w_accept) begin
                r_fv <= 1'b1;
            end else if (o_push) begin
                r_fv <= 1'b0;
            end
            if (w_store) begin
                r_valid[w_code_idx] <= i_glyph_present;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind    <= w_kind;
            r_present <= r_valid[w_idx];
            r_rd      <= r_mem[w_idx];
        end
        if (w_store && i_glyph_present) begin
            r_mem[w_code_idx] <= i_glyph;
        end
    end

    assign o_push     = r_fv && !i_full;
    assign o_stall    = r_fv && i_full;
    assign o_cmd.kind = r_kind;
    // a lookup that finds no valid entry, not even entry 0, reads as all zero metrics
    assign o_cmd.glyph = (r_kind == K_GLYPH && r_present) ? r_rd : '0;

endmodule

[rtl/core/glq_queue.sv]
// ----------------------------------------------------------------------------
// glq_queue: short command queue between front and back
// Lets the front keep taking items while the back works on a glyph.
// ----------------------------------------------------------------------------
module glq_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  glq_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output glq_pkg::t_cmd o_head
);
    import glq_pkg::*;

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_cnt;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        r = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

[rtl/core/glq_div.sv]
// ----------------------------------------------------------------------------
// glq_div: iterative texture coordinate divider
// Computes min(texel * 65536 / size, 65536) with a zero size taken as one,
// several quotient bits per cycle.
// ----------------------------------------------------------------------------
module glq_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [12:0] i_texel,
    input  logic [12:0] i_size,
    output logic        o_done,
    output logic [16:0] o_coord
);
    import glq_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [12:0]          r_d;
    logic [12:0]          r_rem;
    logic [15:0]          r_q;
    logic                 r_q16;
    logic                 r_ovf;

    logic [12:0] w_d;
    logic        w_ovf;
    logic        w_ge;
    logic [12:0] w_rem0;
    logic [12:0] w_step_rem;
    logic [15:0] w_step_q;
    logic        w_last;
    logic [16:0] w_full;

    assign w_d    = (i_size == '0) ? 13'd1 : i_size;
    // quotient reaches 2^17 exactly when texel >= 2 * size
    assign w_ovf  = ({1'b0, i_texel} >= {w_d, 1'b0});
    assign w_ge   = (i_texel >= w_d);
    assign w_rem0 = w_ovf ? '0 : (w_ge ? i_texel - w_d : i_texel);
    assign w_last = r_busy && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));

    always_comb begin
        logic [13:0] t;
        logic [12:0] rem;
        logic [15:0] q;
        rem = r_rem;
        q   = r_q;
        for (int i = 0; i < DIV_RADIX_BITS; i++) begin
            t = {rem, 1'b0};
            if (t >= {1'b0, r_d}) begin
                rem = 13'(t - {1'b0, r_d});
                q   = {q[14:0], 1'b1};
            end else begin
                rem = t[12:0];
                q   = {q[14:0], 1'b0};
            end
        end
        w_step_rem = rem;
        w_step_q   = q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d   <= w_d;
            r_rem <= w_rem0;
            r_q   <= '0;
            r_q16 <= w_ge;
            r_ovf <= w_ovf;
        end else if (r_busy) begin
            r_rem <= w_step_rem;
            r_q   <= w_step_q;
        end
    end

    assign w_full  = {r_q16, r_q};
    assign o_done  = r_done;
    assign o_coord = (r_ovf || w_full > Q16_ONE) ? Q16_ONE : w_full;

endmodule

[rtl/core/glq_back.sv]
// ----------------------------------------------------------------------------
// glq_back: execution side of the glyph quad layout block
// Keeps the cursor, builds quads and texture coordinates, and holds the
// result register of the output channel.
// ----------------------------------------------------------------------------
module glq_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  glq_pkg::t_cfg i_cfg,
    input  logic          i_empty,
    input  glq_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [2:0]    o_status,
    output logic [15:0]   o_left,
    output logic [15:0]   o_top,
    output logic [15:0]   o_right,
    output logic [15:0]   o_bottom,
    output logic [16:0]   o_u_left,
    output logic [16:0]   o_v_top,
    output logic [16:0]   o_u_right,
    output logic [16:0]   o_v_bottom,
    output logic [15:0]   o_pen_x
);
    import glq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_DIV  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state      r_state;
    t_state      n_state;
    t_cmd        r_cmd;
    logic [1:0]  r_sel;
    logic [16:0] r_tex [4];
    logic [15:0] r_pen_col;
    logic [15:0] r_pen_row;
    logic [15:0] n_pen_col;
    logic [15:0] n_pen_row;

    logic        r_ovalid;
    t_status     r_status;
    logic [15:0] r_left, r_top, r_right, r_bottom, r_pen_x;
    logic [16:0] r_u_left, r_v_top, r_u_right, r_v_bottom;

    t_status     n_status;
    logic [15:0] n_left, n_top, n_right, n_bottom;
    logic [16:0] n_u_left, n_v_top, n_u_right, n_v_bottom;

    logic        w_out_free;
    logic        w_draw;
    logic        w_div_start;
    logic        w_div_done;
    logic [1:0]  w_div_sel;
    logic [12:0] w_texel;
    logic [12:0] w_size;
    logic [16:0] w_coord;

    logic [17:0] w_l, w_t, w_r, w_b, w_col_adv, w_row_lh;

    assign w_out_free = !r_ovalid || !i_stall;
    assign o_pop      = (r_state == S_IDLE) && !i_empty;
    assign w_draw     = (r_cmd.kind == K_GLYPH)
                        && ((r_cmd.glyph.width | r_cmd.glyph.height) != '0);
    assign w_div_sel  = (r_state == S_EVAL) ? 2'd0 : r_sel + 2'd1;
    assign w_div_start = ((r_state == S_EVAL) && w_draw)
                         || ((r_state == S_DIV) && w_div_done && (r_sel != 2'd3));

    always_comb begin
        case (w_div_sel)
            2'd0:    w_texel = {1'b0, r_cmd.glyph.atlas_x};
            2'd1:    w_texel = {1'b0, r_cmd.glyph.atlas_y};
            2'd2:    w_texel = {1'b0, r_cmd.glyph.atlas_x} + {5'b0, r_cmd.glyph.width};
            default: w_texel = {1'b0, r_cmd.glyph.atlas_y} + {5'b0, r_cmd.glyph.height};
        endcase
    end
    assign w_size = w_div_sel[0] ? i_cfg.atlas_height : i_cfg.atlas_width;

    glq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_texel (w_texel),
        .i_size  (w_size),
        .o_done  (w_div_done),
        .o_coord (w_coord)
    );

    // quad corners and cursor moves, exact in 18 bits before saturation
    assign w_l = {{2{r_pen_col[15]}}, r_pen_col} + {{10{r_cmd.glyph.off_x[7]}}, r_cmd.glyph.off_x};
    assign w_t = {{2{r_pen_row[15]}}, r_pen_row} + {{10{r_cmd.glyph.off_y[7]}}, r_cmd.glyph.off_y};
    assign w_r = w_l + {10'b0, r_cmd.glyph.width};
    assign w_b = w_t + {10'b0, r_cmd.glyph.height};
    assign w_col_adv = {{2{r_pen_col[15]}}, r_pen_col} + {10'b0, r_cmd.glyph.advance};
    assign w_row_lh  = {{2{r_pen_row[15]}}, r_pen_row} + {10'b0, i_cfg.line_height};

    always_comb begin
        n_status   = ST_NOTHING;
        n_left     = '0;
        n_top      = '0;
        n_right    = '0;
        n_bottom   = '0;
        n_u_left   = '0;
        n_v_top    = '0;
        n_u_right  = '0;
        n_v_bottom = '0;
        n_pen_col  = r_pen_col;
        n_pen_row  = r_pen_row;
        case (r_cmd.kind)
            K_STORED: begin
                n_status = ST_STORED;
            end
            K_START: begin
                n_status  = ST_CURSOR_RESET;
                n_pen_col = '0;
                n_pen_row = '0;
            end
            K_NEWLINE: begin
                n_status  = ST_LINE_BREAK;
                n_pen_col = '0;
                n_pen_row = sat16($signed(w_row_lh));
            end
            K_GLYPH: begin
                n_pen_col = sat16($signed(w_col_adv));
                if (w_draw) begin
                    n_status   = ST_QUAD;
                    n_left     = sat16($signed(w_l));
                    n_top      = sat16($signed(w_t));
                    n_right    = sat16($signed(w_r));
                    n_bottom   = sat16($signed(w_b));
                    n_u_left   = r_tex[0];
                    n_v_top    = r_tex[1];
                    n_u_right  = r_tex[2];
                    n_v_bottom = r_tex[3];
                end
            end
            default: begin
                n_status = ST_NOTHING;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (o_pop) n_state = S_EVAL;
            S_EVAL:  n_state = w_draw ? S_DIV : S_OUT;
            S_DIV:   if (w_div_done && r_sel == 2'd3) n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ovalid  <= 1'b0;
            r_pen_col <= '0;
            r_pen_row <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid  <= 1'b1;
                r_pen_col <= n_pen_col;
                r_pen_row <= n_pen_row;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (r_state == S_EVAL) begin
            r_sel <= 2'd0;
        end else if (r_state == S_DIV && w_div_done) begin
            r_tex[r_sel] <= w_coord;
            r_sel        <= r_sel + 2'd1;
        end
        if (r_state == S_OUT && w_out_free) begin
            r_status   <= n_status;
            r_left     <= n_left;
            r_top      <= n_top;
            r_right    <= n_right;
            r_bottom   <= n_bottom;
            r_u_left   <= n_u_left;
            r_v_top    <= n_v_top;
            r_u_right  <= n_u_right;
            r_v_bottom <= n_v_bottom;
            r_pen_x    <= n_pen_col;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_status   = r_status;
    assign o_left     = r_left;
    assign o_top      = r_top;
    assign o_right    = r_right;
    assign o_bottom   = r_bottom;
    assign o_u_left   = r_u_left;
    assign o_v_top    = r_v_top;
    assign o_u_right  = r_u_right;
    assign o_v_bottom = r_v_bottom;
    assign o_pen_x    = r_pen_x;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside of the divide phase");

    a_pop_to_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == S_EVAL)
        else $error("popped command not evaluated");

    a_hold_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && !w_out_free |=> r_state == S_OUT && $stable(r_pen_col))
        else $error("result issued while output register busy");

    a_tex_zero_no_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_status != ST_QUAD |-> r_u_left == '0 && r_v_top == '0
            && r_u_right == '0 && r_v_bottom == '0 && r_left == '0)
        else $error("quad fields set on a result without a quad");

    a_pen_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_pen_col[15] && !r_pen_row[15])
        else $error("cursor went negative");

endmodule

[rtl/core/glyph_quad_layout.sv]
// ----------------------------------------------------------------------------
// glyph_quad_layout: bitmap font text layout engine
// Glyph metric table, text cursor, screen quads and atlas coordinates.
// ----------------------------------------------------------------------------
//  channel   handshake                      payload
//  input     i_valid / o_stall              i_action .. i_advance_x
//  output    o_valid / i_stall              o_status .. o_pen_x
//  config    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  A drawn glyph passes the back end in order: pop, evaluate, four texture
//  coordinate divisions in turn on one divider (4 quotient bits a cycle, then
//  a handover of the result), and the output load. Every other item skips the
//  divisions. The front takes one item a cycle into a 2-deep command queue,
//  so it stalls only when the queue is full.
//  Reset clears the glyph table valid bits and the cursor at once; no
//  clearing pass. Config writes are always ready.
// ----------------------------------------------------------------------------
module glyph_quad_layout (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_char_code,
    input  logic        i_glyph_present,
    input  logic [11:0] i_atlas_x,
    input  logic [11:0] i_atlas_y,
    input  logic [7:0]  i_glyph_width,
    input  logic [7:0]  i_glyph_height,
    input  logic signed [7:0] i_offset_x,
    input  logic signed [7:0] i_offset_y,
    input  logic [7:0]  i_advance_x,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic signed [15:0] o_left,
    output logic signed [15:0] o_top,
    output logic signed [15:0] o_right,
    output logic signed [15:0] o_bottom,
    output logic [16:0] o_u_left,
    output logic [16:0] o_v_top,
    output logic [16:0] o_u_right,
    output logic [16:0] o_v_bottom,
    output logic signed [15:0] o_pen_x,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);
    import glq_pkg::*;

    t_cfg   r_cfg;
    t_glyph w_glyph;
    t_cmd   w_push_cmd;
    t_cmd   w_head;
    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_height  <= 8'd16;
            r_cfg.atlas_width  <= 13'd256;
            r_cfg.atlas_height <= 13'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LINE_HEIGHT:  r_cfg.line_height  <= i_cfg_data[7:0];
                CFG_ATLAS_WIDTH:  r_cfg.atlas_width  <= i_cfg_data;
                CFG_ATLAS_HEIGHT: r_cfg.atlas_height <= i_cfg_data;
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    assign w_glyph.atlas_x = i_atlas_x;
    assign w_glyph.atlas_y = i_atlas_y;
    assign w_glyph.width   = i_glyph_width;
    assign w_glyph.height  = i_glyph_height;
    assign w_glyph.off_x   = i_offset_x;
    assign w_glyph.off_y   = i_offset_y;
    assign w_glyph.advance = i_advance_x;

    glq_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_action        (i_action),
        .i_char_code     (i_char_code),
        .i_glyph_present (i_glyph_present),
        .i_glyph         (w_glyph),
        .o_push          (w_push),
        .o_cmd           (w_push_cmd),
        .i_full          (w_full)
    );

    glq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    glq_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_empty    (w_empty),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_status   (o_status),
        .o_left     (o_left),
        .o_top      (o_top),
        .o_right    (o_right),
        .o_bottom   (o_bottom),
        .o_u_left   (o_u_left),
        .o_v_top    (o_v_top),
        .o_u_right  (o_u_right),
        .o_v_bottom (o_v_bottom),
        .o_pen_x    (o_pen_x)
    );

endmodule
